FILE: sv/keyed_record_table_lookup_core_macros.svh
// assertion helpers for the record table core
`ifndef KEYED_RECORD_TABLE_LOOKUP_CORE_MACROS_SVH
`define KEYED_RECORD_TABLE_LOOKUP_CORE_MACROS_SVH

// property that must hold in the cycle after the trigger
`define KRT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("check failed");

// property that must hold in the same cycle
`define KRT_SAME(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("check failed");

`endif

FILE: sv/krtl_pkg.sv
`timescale 1ns / 1ps
package krtl_pkg;
   localparam int TableEntriesDefault = 1024;
   localparam int BucketCountDefault  = 256;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_STORED = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // one transaction as it travels from front to back
   typedef struct packed {
      logic        action;
      logic [15:0] font_id;
      logic [15:0] pt_size;
      logic [7:0]  position_class;
      logic [63:0] run_hash;
      logic [31:0] blob_offset;
      logic [31:0] blob_length;
      logic [31:0] box_left;
      logic [31:0] box_right;
      logic [31:0] box_ascent;
      logic [31:0] box_descent;
      logic [31:0] advance_width;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] offset;
      logic [31:0] length;
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] ascent;
      logic [31:0] descent;
      logic [31:0] width;
   } result_type;
endpackage

FILE: sv/krtl_queue.sv
`timescale 1ns / 1ps
module krtl_queue
   import krtl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     not_empty,
   output logic     full,
   output item_type head
);
   // two entry queue
   item_type    slot_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, rd_in, wr_ff, wr_in;

   assign not_empty = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end
endmodule

FILE: sv/krtl_front.sv
`timescale 1ns / 1ps
module krtl_front
   import krtl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  item_type req_item,
   input  logic     q_full,
   output logic     busy,
   output logic     push,
   output item_type push_item
);
   // registers the request before queueing
   item_type hold_ff;
   logic     valid_ff, valid_in;

   assign busy      = valid_ff && q_full;
   assign push      = valid_ff && !q_full;
   assign push_item = hold_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (start && !busy) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (start && !busy) begin
         hold_ff <= req_item;
         // lookup class zero needs no retry: normalize unused load bits not needed
      end
   end
endmodule

FILE: sv/krtl_back.sv
`timescale 1ns / 1ps
module krtl_back
   import krtl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] blob_bytes,
   input  logic        q_valid,
   input  item_type    q_head,
   output logic        pop,
   output logic        rsp_valid,
   output result_type  rsp
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] CountMax = CW'(TABLE_ENTRIES);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_FETCH, S_EMIT} state_type;

   logic [63:0] hash_mem [TABLE_ENTRIES];
   logic [39:0] attr_mem [TABLE_ENTRIES];
   logic [63:0] ext_mem  [TABLE_ENTRIES];
   logic [63:0] side_mem [TABLE_ENTRIES];
   logic [63:0] vert_mem [TABLE_ENTRIES];
   logic [31:0] wid_mem  [TABLE_ENTRIES];

   state_type   state_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic        retry_ff;
   logic [39:0] want_ff;
   logic [63:0] hash_rd_ff, ext_rd_ff, side_rd_ff, vert_rd_ff;
   logic [39:0] attr_rd_ff;
   logic [31:0] wid_rd_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        pop_ff;

   logic [32:0] ext_sum;
   logic        match;
   logic        load_go;
   logic [AW-1:0] rd_addr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign pop       = pop_ff;
   assign rd_addr   = idx_ff[AW-1:0];
   assign match     = (hash_rd_ff == q_head.run_hash) && (attr_rd_ff == want_ff);
   assign ext_sum   = {1'b0, ext_rd_ff[31:0]} + {1'b0, ext_rd_ff[63:32]};
   assign load_go   = (state_ff == S_IDLE) && q_valid && !pop_ff
                      && (q_head.action == ACT_LOAD);

   always_ff @(posedge clock) begin
      if (state_ff == S_READ || state_ff == S_FETCH) begin
         hash_rd_ff <= hash_mem[rd_addr];
         attr_rd_ff <= attr_mem[rd_addr];
         ext_rd_ff  <= ext_mem[rd_addr];
         side_rd_ff <= side_mem[rd_addr];
         vert_rd_ff <= vert_mem[rd_addr];
         wid_rd_ff  <= wid_mem[rd_addr];
      end
      if (load_go && count_ff != CountMax) begin
         hash_mem[count_ff[AW-1:0]] <= q_head.run_hash;
         attr_mem[count_ff[AW-1:0]] <= {q_head.font_id, q_head.pt_size, q_head.position_class};
         ext_mem[count_ff[AW-1:0]]  <= {q_head.blob_length, q_head.blob_offset};
         side_mem[count_ff[AW-1:0]] <= {q_head.box_right, q_head.box_left};
         vert_mem[count_ff[AW-1:0]] <= {q_head.box_descent, q_head.box_ascent};
         wid_mem[count_ff[AW-1:0]]  <= q_head.advance_width;
      end
   end

   // loads append a record; lookups do a linear scan in load order; first key match ends the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         retry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pop_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= load_go || (state_ff == S_EMIT);
         pop_ff       <= load_go || (state_ff == S_EMIT);
         case (state_ff)
            S_IDLE: begin
               if (load_go) begin
                  if (count_ff == CountMax) begin
                     rsp_ff <= result_type'({ST_FULL, 224'd0});
                  end else begin
                     rsp_ff   <= result_type'({ST_STORED, 224'd0});
                     count_ff <= count_ff + 1'b1;
                  end
               end else if (q_valid && !pop_ff) begin
                  idx_ff   <= '0;
                  retry_ff <= 1'b0;
                  want_ff  <= {q_head.font_id, q_head.pt_size, q_head.position_class};
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (idx_ff == count_ff) begin
                  if (!retry_ff && q_head.position_class != 8'd0) begin
                     retry_ff     <= 1'b1;
                     idx_ff       <= '0;
                     want_ff[7:0] <= 8'd0;
                  end else begin
                     rsp_ff   <= result_type'({ST_MISS, 224'd0});
                     state_ff <= S_EMIT;
                  end
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (match) begin
                  if (ext_sum > {1'b0, blob_bytes}) begin
                     idx_ff <= count_ff;
                  end else begin
                     rsp_ff <= {ST_HIT, ext_rd_ff[31:0], ext_rd_ff[63:32],
                                side_rd_ff[31:0], side_rd_ff[63:32],
                                vert_rd_ff[31:0], vert_rd_ff[63:32], wid_rd_ff};
                     state_ff <= S_EMIT;
                  end
                  if (ext_sum > {1'b0, blob_bytes}) begin
                     state_ff <= S_READ;
                  end
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_FETCH: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: sv/keyed_record_table_lookup_core.sv
`timescale 1ns / 1ps
// keyed record table: a load appends a record (stored or full), a lookup scans
// the stored records in load order, a read state and a check state per record,
// one pass per key class, with a class zero retry after a nonzero class pass
// finds no hit, and it ends at its first hit; a request is registered in
// the front register and then in the queue before the back end takes it.
// the scan loop over one read port of the record memories sets the rate.
// results show for one cycle on rsp_valid and cannot be held off; busy means
// the two entry queue and the front register are full. blob_bytes may be
// written only when idle.
module keyed_record_table_lookup_core
   import krtl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [31:0] csr_blob_bytes,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_font_id,
   input  logic [15:0] req_pt_size,
   input  logic [7:0]  req_position_class,
   input  logic [63:0] req_run_hash,
   input  logic [31:0] req_blob_offset,
   input  logic [31:0] req_blob_length,
   input  logic [31:0] req_box_left,
   input  logic [31:0] req_box_right,
   input  logic [31:0] req_box_ascent,
   input  logic [31:0] req_box_descent,
   input  logic [31:0] req_advance_width,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_offset,
   output logic [31:0] rsp_found_length,
   output logic [31:0] rsp_found_left,
   output logic [31:0] rsp_found_right,
   output logic [31:0] rsp_found_ascent,
   output logic [31:0] rsp_found_descent,
   output logic [31:0] rsp_found_width
);
   logic [31:0] blob_bytes_ff;
   item_type    req_item, push_item, head;
   logic        push, pop, q_valid, q_full;
   result_type  rsp;

   assign req_item = {req_action, req_font_id, req_pt_size, req_position_class,
                      req_run_hash, req_blob_offset, req_blob_length, req_box_left,
                      req_box_right, req_box_ascent, req_box_descent, req_advance_width};

   // blob length register
   always_ff @(posedge clock) begin
      if (reset) begin
         blob_bytes_ff <= '0;
      end else if (csr_write) begin
         blob_bytes_ff <= csr_blob_bytes;
      end
   end

   krtl_front u_front (
      .clock, .reset, .start, .req_item, .q_full, .busy, .push, .push_item
   );

   krtl_queue u_queue (
      .clock, .reset, .push, .push_item, .pop, .not_empty(q_valid), .full(q_full), .head
   );

   krtl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .blob_bytes(blob_bytes_ff), .q_valid, .q_head(head), .pop,
      .rsp_valid, .rsp
   );

   assign rsp_status        = rsp.status;
   assign rsp_found_offset  = rsp.offset;
   assign rsp_found_length  = rsp.length;
   assign rsp_found_left    = rsp.left;
   assign rsp_found_right   = rsp.right;
   assign rsp_found_ascent  = rsp.ascent;
   assign rsp_found_descent = rsp.descent;
   assign rsp_found_width   = rsp.width;
endmodule

FILE: sv/krtl_checker.sv
`timescale 1ns / 1ps
`include "keyed_record_table_lookup_core_macros.svh"
module krtl_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status
);
   // a result never follows directly on another
   `KRT_NEXT(a_gap, clock, reset, rsp_valid, !rsp_valid)
   // no result straight out of reset
   `KRT_SAME(a_rst, clock, reset, $past(reset), !rsp_valid)
   // busy only rises after a transaction was taken
   `KRT_SAME(a_busy, clock, reset, $rose(busy), $past(start))
   // a strobed result always carries a known status
   `KRT_SAME(a_known, clock, reset, rsp_valid, !$isunknown(rsp_status))
endmodule

bind keyed_record_table_lookup_core krtl_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_status
);
